FILE: rtl/hrbf_pkg.sv
// Shared types, byte codes and pattern tables for the HTTP request body framer.
`timescale 1ns / 1ps
`default_nettype none

package hrbf_pkg;

  // Default width of the length and chunk-size counters
  localparam int DEF_LENGTH_BITS = 32;

  // Byte codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  // Header patterns, first character leftmost
  localparam int CHUNK_PAT_N  = 26;
  localparam int LENGTH_PAT_N = 15;
  localparam logic [8*CHUNK_PAT_N-1:0]  CHUNK_PAT  = "Transfer-Encoding: chunked";
  localparam logic [8*LENGTH_PAT_N-1:0] LENGTH_PAT = "Content-Length:";
  localparam logic [4:0] CHUNK_PAT_LEN  = 5'd26;
  localparam logic [3:0] LENGTH_PAT_LEN = 4'd15;

  // Header terminator progress (CR LF CR LF)
  localparam logic [1:0] EM_NONE   = 2'd0;
  localparam logic [1:0] EM_CR     = 2'd1;
  localparam logic [1:0] EM_CRLF   = 2'd2;
  localparam logic [1:0] EM_CRLFCR = 2'd3;

  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_FIXED   = 6'b000010,
    PH_SIZE    = 6'b000100,
    PH_DATA    = 6'b001000,
    PH_TRAILER = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  typedef enum logic [3:0] {
    LP_NOTFOUND = 4'b0001,
    LP_SKIP     = 4'b0010,
    LP_DIGITS   = 4'b0100,
    LP_DONE     = 4'b1000
  } lp_step_t;

  typedef enum logic [5:0] {
    SL_START  = 6'b000001,
    SL_ZERO   = 6'b000010,
    SL_DIGITS = 6'b000100,
    SL_REST   = 6'b001000,
    SL_PREFIX = 6'b010000,
    SL_SIGN   = 6'b100000
  } sl_step_t;

  function automatic logic [7:0] chunk_char(input logic [4:0] idx);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < CHUNK_PAT_N; i++) begin
      if (idx == 5'(i)) c = CHUNK_PAT[8*(CHUNK_PAT_N-1-i) +: 8];
    end
    return c;
  endfunction

  function automatic logic [7:0] length_char(input logic [3:0] idx);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < LENGTH_PAT_N; i++) begin
      if (idx == 4'(i)) c = LENGTH_PAT[8*(LENGTH_PAT_N-1-i) +: 8];
    end
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // Returns {valid, value} for a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'b0_0000;
    if (is_digit(b)) r = {1'b1, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      r = {1'b1, b[3:0] + 4'd9};
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/hrbf_size_parse.sv
// Next-state logic for one byte of a chunk size line (hex, saturating).
`timescale 1ns / 1ps
`default_nettype none

module hrbf_size_parse #(
  parameter int LENGTH_BITS = hrbf_pkg::DEF_LENGTH_BITS
) (
  input  wire logic [7:0]             byte_i,
  input  wire hrbf_pkg::sl_step_t     step_i,
  input  wire logic [LENGTH_BITS-1:0] size_i,
  output hrbf_pkg::sl_step_t          step_o,
  output logic [LENGTH_BITS-1:0]      size_o
);
  import hrbf_pkg::*;

  logic [4:0]             hex;
  logic                   sat;
  logic [LENGTH_BITS-1:0] size_acc;

  // Shift in one hex digit, clamp to all ones on overflow
  assign hex      = hex_val(byte_i);
  assign sat      = |size_i[LENGTH_BITS-1 -: 4];
  assign size_acc = sat ? {LENGTH_BITS{1'b1}} : {size_i[LENGTH_BITS-5:0], hex[3:0]};

  always_comb begin
    step_o = step_i;
    size_o = size_i;
    case (step_i)
      SL_START: begin
        if (is_space(byte_i)) begin
          step_o = SL_START;
        end else if (byte_i == CH_PLUS) begin
          step_o = SL_SIGN;
        end else if (hex[4]) begin
          size_o = size_acc;
          step_o = (byte_i == CH_ZERO) ? SL_ZERO : SL_DIGITS;
        end else begin
          step_o = SL_REST;
        end
      end
      SL_SIGN: begin
        if (hex[4]) begin
          size_o = size_acc;
          step_o = (byte_i == CH_ZERO) ? SL_ZERO : SL_DIGITS;
        end else begin
          step_o = SL_REST;
        end
      end
      SL_ZERO: begin
        if (byte_i == CH_LOW_X || byte_i == CH_UP_X) begin
          step_o = SL_PREFIX;
        end else if (hex[4]) begin
          size_o = size_acc;
          step_o = SL_DIGITS;
        end else begin
          step_o = SL_REST;
        end
      end
      SL_PREFIX, SL_DIGITS: begin
        if (hex[4]) begin
          size_o = size_acc;
          step_o = SL_DIGITS;
        end else begin
          step_o = SL_REST;
        end
      end
      default: begin
        step_o = SL_REST;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/hrbf_hdr_scan.sv
// Header scanner: chunked marker match and Content-Length value parse.
`timescale 1ns / 1ps
`default_nettype none

module hrbf_hdr_scan #(
  parameter int LENGTH_BITS = hrbf_pkg::DEF_LENGTH_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step_i,
  input  wire logic                   clear_i,
  input  wire logic [7:0]             byte_i,
  input  wire logic                   prev_cr_i,
  output logic                        chunked_o,
  output logic [LENGTH_BITS-1:0]      body_len_o
);
  import hrbf_pkg::*;

  logic [4:0]             chunk_match_r, chunk_match_nxt;
  logic                   chunked_seen_r, chunked_seen_nxt;
  logic [3:0]             length_match_r, length_match_nxt;
  lp_step_t               lp_step_r, lp_step_nxt;
  logic [LENGTH_BITS-1:0] body_len_r, body_len_nxt;

  logic [LENGTH_BITS+3:0] len_wide;
  logic [LENGTH_BITS+3:0] dec_acc;
  logic [LENGTH_BITS-1:0] dec_sat;
  logic [4:0]             chunk_adv;
  logic [3:0]             length_adv;

  // Decimal accumulate: len*10 + digit, clamp to all ones
  assign len_wide = {4'b0000, body_len_r};
  assign dec_acc  = (len_wide << 3) + (len_wide << 1) + {{LENGTH_BITS{1'b0}}, byte_i[3:0]};
  assign dec_sat  = (|dec_acc[LENGTH_BITS+3:LENGTH_BITS]) ? {LENGTH_BITS{1'b1}}
                                                           : dec_acc[LENGTH_BITS-1:0];

  // Advance the pattern matchers; the first character occurs once in each pattern
  assign chunk_adv  = (chunk_match_r < CHUNK_PAT_LEN && byte_i == chunk_char(chunk_match_r))
                      ? chunk_match_r + 5'd1
                      : ((byte_i == chunk_char(5'd0)) ? 5'd1 : 5'd0);
  assign length_adv = (length_match_r < LENGTH_PAT_LEN && byte_i == length_char(length_match_r))
                      ? length_match_r + 4'd1
                      : ((byte_i == length_char(4'd0)) ? 4'd1 : 4'd0);

  always_comb begin
    chunk_match_nxt  = chunk_match_r;
    chunked_seen_nxt = chunked_seen_r;
    length_match_nxt = length_match_r;
    lp_step_nxt      = lp_step_r;
    body_len_nxt     = body_len_r;
    if (step_i) begin
      // Content-Length value parse
      case (lp_step_r)
        LP_NOTFOUND: begin
          length_match_nxt = length_adv;
          if (length_adv == LENGTH_PAT_LEN) lp_step_nxt = LP_SKIP;
        end
        LP_SKIP: begin
          if (byte_i == CH_LF && prev_cr_i) begin
            lp_step_nxt = LP_DONE;
          end else if (is_space(byte_i)) begin
            lp_step_nxt = LP_SKIP;
          end else if (byte_i == CH_PLUS) begin
            lp_step_nxt = LP_DIGITS;
          end else if (is_digit(byte_i)) begin
            body_len_nxt = {{(LENGTH_BITS-4){1'b0}}, byte_i[3:0]};
            lp_step_nxt  = LP_DIGITS;
          end else begin
            lp_step_nxt = LP_DONE;
          end
        end
        LP_DIGITS: begin
          if (is_digit(byte_i)) body_len_nxt = dec_sat;
          else lp_step_nxt = LP_DONE;
        end
        default: begin
          lp_step_nxt = lp_step_r;
        end
      endcase
      // Chunked marker match
      if (!chunked_seen_r) begin
        chunk_match_nxt = chunk_adv;
        if (chunk_adv == CHUNK_PAT_LEN) chunked_seen_nxt = 1'b1;
      end
    end
    // Drop everything at connection end
    if (clear_i) begin
      chunk_match_nxt  = 5'd0;
      chunked_seen_nxt = 1'b0;
      length_match_nxt = 4'd0;
      lp_step_nxt      = LP_NOTFOUND;
      body_len_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_match_r  <= 5'd0;
      chunked_seen_r <= 1'b0;
      length_match_r <= 4'd0;
      lp_step_r      <= LP_NOTFOUND;
      body_len_r     <= '0;
    end else begin
      chunk_match_r  <= chunk_match_nxt;
      chunked_seen_r <= chunked_seen_nxt;
      length_match_r <= length_match_nxt;
      lp_step_r      <= lp_step_nxt;
      body_len_r     <= body_len_nxt;
    end
  end

  assign chunked_o  = chunked_seen_nxt;
  assign body_len_o = body_len_nxt;

endmodule

`default_nettype wire

FILE: rtl/http_request_body_framer.sv
// Top level of the HTTP request body framer: phase control and result register.
// A result is registered and appears on out_* in the cycle after its request is accepted.
// Throughput: one request per cycle; in_ready is high whenever the result
// register is empty or being drained by out_ready in the same cycle.
// All per-byte work is one pass of matching and a constant-multiply accumulate.
// Reset (rst_n low, synchronous): header phase, all counters cleared, no result.
`timescale 1ns / 1ps
`default_nettype none

module http_request_body_framer #(
  parameter int LENGTH_BITS = hrbf_pkg::DEF_LENGTH_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_conn_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_has_byte,
  output logic            out_in_body,
  output logic            out_last,
  output logic            out_complete
);
  import hrbf_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [1:0]             end_match_r, end_match_nxt;
  logic [LENGTH_BITS-1:0] remaining_r, remaining_nxt;
  sl_step_t               sl_step_r, sl_step_nxt;
  logic                   any_seen_r, any_seen_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_byte_r;
  logic                   out_has_byte_r, out_in_body_r, out_last_r, out_complete_r;

  logic                   accept;
  logic                   hdr_step;
  logic                   hdr_clear;
  logic                   prev_cr;
  logic                   chunked;
  logic [LENGTH_BITS-1:0] body_len;
  sl_step_t               sp_step;
  logic [LENGTH_BITS-1:0] sp_size;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic                   term;

  logic                   emit;
  logic [7:0]             r_byte;
  logic                   r_has, r_body, r_last, r_complete;

  // Take a request whenever the result register is free or draining
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign hdr_step  = accept && !in_conn_end && (phase_r == PH_HEADER);
  assign hdr_clear = accept && in_conn_end;
  assign prev_cr   = (end_match_r == EM_CR) || (end_match_r == EM_CRLFCR);
  assign rem_dec   = remaining_r - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

  hrbf_hdr_scan #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_hdr_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_i     (hdr_step),
    .clear_i    (hdr_clear),
    .byte_i     (in_byte),
    .prev_cr_i  (prev_cr),
    .chunked_o  (chunked),
    .body_len_o (body_len)
  );

  hrbf_size_parse #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_size_parse (
    .byte_i (in_byte),
    .step_i (sl_step_r),
    .size_i (remaining_r),
    .step_o (sp_step),
    .size_o (sp_size)
  );

  // Phase control and result selection
  always_comb begin
    phase_nxt     = phase_r;
    end_match_nxt = end_match_r;
    remaining_nxt = remaining_r;
    sl_step_nxt   = sl_step_r;
    any_seen_nxt  = any_seen_r;
    term          = 1'b0;
    emit          = 1'b0;
    r_byte        = in_byte;
    r_has         = 1'b0;
    r_body        = 1'b0;
    r_last        = 1'b0;
    r_complete    = 1'b0;
    if (accept) begin
      if (in_conn_end) begin
        // Close out an open request, then start over
        emit          = any_seen_r && (phase_r != PH_DONE);
        r_byte        = 8'h00;
        r_last        = 1'b1;
        phase_nxt     = PH_HEADER;
        end_match_nxt = EM_NONE;
        remaining_nxt = '0;
        sl_step_nxt   = SL_START;
        any_seen_nxt  = 1'b0;
      end else begin
        any_seen_nxt = 1'b1;
        case (phase_r)
          PH_HEADER: begin
            emit  = 1'b1;
            r_has = 1'b1;
            if (in_byte == CH_CR) begin
              end_match_nxt = (end_match_r == EM_CRLF) ? EM_CRLFCR : EM_CR;
            end else if (in_byte == CH_LF && end_match_r == EM_CR) begin
              end_match_nxt = EM_CRLF;
            end else if (in_byte == CH_LF && end_match_r == EM_CRLFCR) begin
              term = 1'b1;
            end else begin
              end_match_nxt = EM_NONE;
            end
            if (term) begin
              end_match_nxt = EM_NONE;
              if (chunked) begin
                phase_nxt     = PH_SIZE;
                sl_step_nxt   = SL_START;
                remaining_nxt = '0;
              end else if (body_len == '0) begin
                phase_nxt  = PH_DONE;
                r_last     = 1'b1;
                r_complete = 1'b1;
              end else begin
                remaining_nxt = body_len;
                phase_nxt     = PH_FIXED;
              end
            end
          end
          PH_FIXED: begin
            remaining_nxt = rem_dec;
            emit          = 1'b1;
            r_has         = 1'b1;
            r_body        = 1'b1;
            if (rem_dec == '0) begin
              phase_nxt  = PH_DONE;
              r_last     = 1'b1;
              r_complete = 1'b1;
            end
          end
          PH_SIZE: begin
            end_match_nxt = (in_byte == CH_CR) ? EM_CR : EM_NONE;
            if (in_byte == CH_LF && end_match_r == EM_CR) begin
              end_match_nxt = EM_NONE;
              if (remaining_r == '0) begin
                phase_nxt  = PH_DONE;
                emit       = 1'b1;
                r_byte     = 8'h00;
                r_last     = 1'b1;
                r_complete = 1'b1;
              end else begin
                phase_nxt = PH_DATA;
              end
            end else begin
              sl_step_nxt   = sp_step;
              remaining_nxt = sp_size;
            end
          end
          PH_DATA: begin
            remaining_nxt = rem_dec;
            emit          = 1'b1;
            r_has         = 1'b1;
            r_body        = 1'b1;
            if (rem_dec == '0) begin
              phase_nxt   = PH_TRAILER;
              sl_step_nxt = SL_START;
            end
          end
          PH_TRAILER: begin
            // Skip two bytes; the step register counts the first one
            if (sl_step_r == SL_START) begin
              sl_step_nxt = SL_ZERO;
            end else begin
              phase_nxt     = PH_SIZE;
              sl_step_nxt   = SL_START;
              end_match_nxt = EM_NONE;
              remaining_nxt = '0;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  // Load the result register on a new result, clear it when drained
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept && emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      end_match_r <= EM_NONE;
      remaining_r <= '0;
      sl_step_r   <= SL_START;
      any_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      end_match_r <= end_match_nxt;
      remaining_r <= remaining_nxt;
      sl_step_r   <= sl_step_nxt;
      any_seen_r  <= any_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_byte_r     <= r_byte;
      out_has_byte_r <= r_has;
      out_in_body_r  <= r_body;
      out_last_r     <= r_last;
      out_complete_r <= r_complete;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_has_byte = out_has_byte_r;
  assign out_in_body  = out_in_body_r;
  assign out_last     = out_last_r;
  assign out_complete = out_complete_r;

endmodule

`default_nettype wire

FILE: rtl/hrbf_checker.sv
// Port-level checker for the HTTP request body framer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hrbf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] in_byte,
  input wire logic       in_conn_end,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_has_byte,
  input wire logic       out_in_body,
  input wire logic       out_last,
  input wire logic       out_complete
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
      && $stable(out_complete) && $stable(out_has_byte) && $stable(out_in_body))
    else $error("stalled result changed");

  // Never refuse a request while the result side is empty
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty result register");

  // A complete flag only comes with the end of a request
  a_complete_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_complete |-> out_last)
    else $error("complete without last");

  // Status-only results always end a request and carry no body
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_last && !out_in_body && (out_byte == 8'h00))
    else $error("malformed status-only result");

  // A closed connection never yields a data result next cycle
  a_close_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_conn_end |=> !out_valid || (!out_has_byte && !out_complete))
    else $error("connection end produced a data or complete result");

endmodule

bind http_request_body_framer hrbf_checker u_hrbf_checker (.*);

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for the HTTP request body framer: directed cases and random framed traffic.
`timescale 1ns / 1ps

module tb_top;
  import hrbf_pkg::*;

  localparam int          LEN_BITS   = DEF_LENGTH_BITS;
  localparam logic [63:0] LEN_MAX    = (64'd1 << LEN_BITS) - 64'd1;
  localparam int          LONG_HOLD  = 50;
  localparam int          PHASE_REQS = 90;

  // One byte request as queued for the driver, with its traffic shaping
  typedef struct {
    logic [7:0] b;
    logic       end_conn;
    int         send_idle;
    int         recv_idle;
    bit         hold;
    bit         drain;
  } byte_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       in_body;
    logic       last;
    logic       complete;
  } frame_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_conn_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic       out_in_body;
  logic       out_last;
  logic       out_complete;

  byte_req_t pending_reqs[$];
  frame_t    expected_frames[$];
  byte_req_t in_flight;
  bit        in_took = 1'b0;
  int        errors = 0;
  int        gen_send_idle = 0;
  int        gen_recv_idle = 0;
  bit        hold_next = 1'b0;
  bit        drain_next = 1'b0;
  int        recv_idle_pct = 0;
  int        hold_asked = 0;
  int        hold_served = 0;
  int        hold_left = 0;

  // Predicted framer state
  phase_t      ph;
  lp_step_t    lp;
  sl_step_t    sl;
  logic [1:0]  em;
  int          chunk_m;
  int          length_m;
  bit          chunked;
  bit          seen_byte;
  bit          trailer_second;
  logic [63:0] body_len;
  logic [63:0] remaining;

  string chunk_marker  = "Transfer-Encoding: chunked";
  string length_marker = "Content-Length:";

  http_request_body_framer #(.LENGTH_BITS(LEN_BITS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_conn_end  (in_conn_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_in_body  (out_in_body),
    .out_last     (out_last),
    .out_complete (out_complete)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  task automatic framer_clear();
    ph = PH_HEADER;
    lp = LP_NOTFOUND;
    sl = SL_START;
    em = EM_NONE;
    chunk_m = 0;
    length_m = 0;
    chunked = 1'b0;
    seen_byte = 1'b0;
    trailer_second = 1'b0;
    body_len = '0;
    remaining = '0;
  endtask

  function automatic int marker_step(int m, logic [7:0] b, string pat);
    if (m < pat.len() && b == pat[m]) return m + 1;
    return (b == pat[0]) ? 1 : 0;
  endfunction

  function automatic bit blank(logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic bit dec_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic int hex_digit(logic [7:0] b);
    if (dec_digit(b)) return int'(b) - 'h30;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
    return -1;
  endfunction

  function automatic logic [63:0] sat_accum(logic [63:0] v, logic [63:0] base,
                                            logic [63:0] d);
    if (v > (LEN_MAX - d) / base) return LEN_MAX;
    return v * base + d;
  endfunction

  // Header byte: track length value, chunked marker and the blank line
  task automatic frame_header(input logic [7:0] b, inout frame_t r);
    bit prev_cr;
    bit term;
    prev_cr = (em == EM_CR) || (em == EM_CRLFCR);
    term = 1'b0;
    if (lp == LP_NOTFOUND) begin
      length_m = marker_step(length_m, b, length_marker);
      if (length_m == length_marker.len()) lp = LP_SKIP;
    end else if (lp == LP_SKIP) begin
      if (b == CH_LF && prev_cr) lp = LP_DONE;
      else if (!blank(b)) begin
        if (b == CH_PLUS) lp = LP_DIGITS;
        else if (dec_digit(b)) begin
          body_len = 64'(b - CH_ZERO);
          lp = LP_DIGITS;
        end else lp = LP_DONE;
      end
    end else if (lp == LP_DIGITS) begin
      if (dec_digit(b)) body_len = sat_accum(body_len, 64'd10, 64'(b - CH_ZERO));
      else lp = LP_DONE;
    end

    if (!chunked) begin
      chunk_m = marker_step(chunk_m, b, chunk_marker);
      if (chunk_m == chunk_marker.len()) chunked = 1'b1;
    end

    if (b == CH_CR) em = (em == EM_CRLF) ? EM_CRLFCR : EM_CR;
    else if (b == CH_LF && em == EM_CR) em = EM_CRLF;
    else if (b == CH_LF && em == EM_CRLFCR) term = 1'b1;
    else em = EM_NONE;

    r.data = b;
    r.has_byte = 1'b1;
    if (term) begin
      em = EM_NONE;
      if (chunked) begin
        ph = PH_SIZE;
        sl = SL_START;
        remaining = '0;
      end else if (body_len == 0) begin
        ph = PH_DONE;
        r.last = 1'b1;
        r.complete = 1'b1;
      end else begin
        remaining = body_len;
        ph = PH_FIXED;
      end
    end
  endtask

  // Size line byte: accumulate hex size, end the message on a zero size
  task automatic frame_size(input logic [7:0] b, output logic produced,
                            inout frame_t r);
    bit prev_cr;
    int hv;
    prev_cr = (em == EM_CR);
    hv = hex_digit(b);
    em = (b == CH_CR) ? EM_CR : EM_NONE;
    produced = 1'b0;
    if (b == CH_LF && prev_cr) begin
      em = EM_NONE;
      if (remaining == 0) begin
        ph = PH_DONE;
        produced = 1'b1;
        r.last = 1'b1;
        r.complete = 1'b1;
      end else ph = PH_DATA;
    end else begin
      case (sl)
        SL_START, SL_SIGN: begin
          if (!(sl == SL_START && blank(b))) begin
            if (sl == SL_START && b == CH_PLUS) sl = SL_SIGN;
            else if (hv >= 0) begin
              remaining = sat_accum(remaining, 64'd16, 64'(hv));
              if (b == CH_ZERO) sl = SL_ZERO;
              else sl = SL_DIGITS;
            end else sl = SL_REST;
          end
        end
        SL_ZERO, SL_PREFIX, SL_DIGITS: begin
          if (sl == SL_ZERO && (b == CH_LOW_X || b == CH_UP_X)) sl = SL_PREFIX;
          else if (hv >= 0) begin
            remaining = sat_accum(remaining, 64'd16, 64'(hv));
            sl = SL_DIGITS;
          end else sl = SL_REST;
        end
        default: sl = SL_REST;
      endcase
    end
  endtask

  // Advance the predicted framer by one request; give its result, if any
  task automatic frame_byte(input logic [7:0] b, input logic conn_end,
                            output logic produced, output frame_t r);
    r = '0;
    produced = 1'b0;
    if (conn_end) begin
      if (seen_byte && ph != PH_DONE) begin
        produced = 1'b1;
        r.last = 1'b1;
      end
      framer_clear();
      return;
    end
    seen_byte = 1'b1;
    case (ph)
      PH_HEADER: begin
        frame_header(b, r);
        produced = 1'b1;
      end
      PH_FIXED: begin
        remaining = (remaining - 64'd1) & LEN_MAX;
        produced = 1'b1;
        r.data = b;
        r.has_byte = 1'b1;
        r.in_body = 1'b1;
        if (remaining == 0) begin
          ph = PH_DONE;
          r.last = 1'b1;
          r.complete = 1'b1;
        end
      end
      PH_SIZE: frame_size(b, produced, r);
      PH_DATA: begin
        remaining = (remaining - 64'd1) & LEN_MAX;
        produced = 1'b1;
        r.data = b;
        r.has_byte = 1'b1;
        r.in_body = 1'b1;
        if (remaining == 0) begin
          ph = PH_TRAILER;
          trailer_second = 1'b0;
        end
      end
      PH_TRAILER: begin
        if (!trailer_second) trailer_second = 1'b1;
        else begin
          ph = PH_SIZE;
          sl = SL_START;
          em = EM_NONE;
          remaining = '0;
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_req(logic [7:0] b, logic e);
    byte_req_t r;
    r.b = b;
    r.end_conn = e;
    r.send_idle = gen_send_idle;
    r.recv_idle = gen_recv_idle;
    r.hold = hold_next;
    r.drain = drain_next;
    hold_next = 1'b0;
    drain_next = 1'b0;
    pending_reqs.push_back(r);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_req(s[i], 1'b0);
  endtask

  task automatic push_crlf();
    push_req(CH_CR, 1'b0);
    push_req(CH_LF, 1'b0);
  endtask

  task automatic push_line(string s);
    push_text(s);
    push_crlf();
  endtask

  // Close the connection; the byte lane carries junk
  task automatic close_conn();
    push_req(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic push_random_bytes(int n);
    repeat (n) push_req(8'($urandom_range(255)), 1'b0);
  endtask

  function automatic string hex_text(int unsigned n);
    string s;
    int unsigned d;
    s = "";
    do begin
      d = n % 16;
      if (d < 10) s = $sformatf("%c%s", 8'h30 + d, s);
      else if ($urandom_range(1)) s = $sformatf("%c%s", 8'h41 + d - 10, s);
      else s = $sformatf("%c%s", 8'h61 + d - 10, s);
      n = n / 16;
    end while (n != 0);
    return s;
  endfunction

  function automatic string blank_run();
    string s;
    s = "";
    repeat ($urandom_range(2)) s = {s, ($urandom_range(1) ? " " : "\t")};
    return s;
  endfunction

  task automatic add_filler_line();
    string s;
    s = "X-";
    repeat ($urandom_range(1, 8)) s = $sformatf("%s%c", s, 8'($urandom_range(33, 126)));
    push_line(s);
  endtask

  task automatic add_fixed_message();
    int len;
    int sent;
    len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 16);
    push_line("POST / HTTP/1.1");
    if ($urandom_range(1)) add_filler_line();
    push_text("Content-Length:");
    push_text(blank_run());
    if ($urandom_range(3) == 0) push_text("+");
    if ($urandom_range(4) == 0) push_text("00");
    push_text($sformatf("%0d", len));
    if ($urandom_range(5) == 0) push_text(" ;x");
    push_crlf();
    if ($urandom_range(1)) add_filler_line();
    push_crlf();
    // mostly full bodies with some excess, sometimes cut short
    sent = ($urandom_range(4) == 0) ? $urandom_range(len) : len + $urandom_range(3);
    push_random_bytes(sent);
    close_conn();
  endtask

  task automatic add_chunked_message();
    int n_chunks;
    int size;
    string line;
    push_line("POST /c HTTP/1.1");
    if ($urandom_range(3) == 0) push_line("Content-Length: 7");
    if ($urandom_range(4) == 0) push_line("TTransfer-Encoding: chunked");
    else push_line("Transfer-Encoding: chunked");
    if ($urandom_range(1)) add_filler_line();
    push_crlf();
    n_chunks = $urandom_range(3);
    for (int i = 0; i < n_chunks; i++) begin
      size = $urandom_range(1, 12);
      line = blank_run();
      if ($urandom_range(4) == 0) line = {line, "+"};
      if ($urandom_range(3) == 0) line = {line, ($urandom_range(1) ? "0x" : "0X")};
      if ($urandom_range(4) == 0) line = {line, "0"};
      line = {line, hex_text(size)};
      case ($urandom_range(3))
        0: line = {line, ";n=v"};
        1: line = {line, " junk"};
        default: ;
      endcase
      push_line(line);
      // drop the connection inside chunk data now and then
      if ($urandom_range(11) == 0) begin
        push_random_bytes($urandom_range(size - 1));
        close_conn();
        return;
      end
      push_random_bytes(size);
      if ($urandom_range(9) == 0) push_random_bytes(2);
      else push_crlf();
    end
    case ($urandom_range(5))
      0: push_line("000");
      1: push_line("0;end");
      2: push_line(" 0x0");
      3: push_line("-1");
      4: push_line("g");
      default: push_line("0");
    endcase
    if ($urandom_range(2) == 0) push_random_bytes($urandom_range(1, 4));
    close_conn();
  endtask

  task automatic add_noise_message();
    if ($urandom_range(2) == 0) begin
      push_line("GET / HTTP/1.1");
      push_crlf();
      push_random_bytes($urandom_range(2));
    end else begin
      repeat ($urandom_range(1, 24)) begin
        if ($urandom_range(9) < 7) push_req(8'($urandom_range(255)), 1'b0);
        else push_req($urandom_range(1) ? CH_CR : CH_LF, 1'b0);
      end
    end
    close_conn();
  endtask

  task automatic add_message();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) add_fixed_message();
    else if (pick < 82) add_chunked_message();
    else add_noise_message();
  endtask

  task automatic add_directed();
    // close before any byte: silent
    close_conn();
    // bare header, zero length; excess dropped, silent close
    push_crlf();
    push_crlf();
    push_text("x");
    close_conn();
    // signed length, extreme body bytes, one excess byte
    push_line("Content-Length: +3");
    push_crlf();
    push_req(8'h00, 1'b0);
    push_req(8'hFF, 1'b0);
    push_req(8'h80, 1'b0);
    push_req(8'h7F, 1'b0);
    close_conn();
    // CR LF right after the name ends the value
    push_line("Content-Length:");
    push_crlf();
    close_conn();
    // lowercase name ignored, minus sign ends the number
    push_line("content-length: 4");
    push_line("Content-Length: -5");
    push_crlf();
    close_conn();
    // saturating length, truncated body
    push_line("Content-Length: 99999999999");
    push_crlf();
    push_text("ab");
    close_conn();
    // empty chunked body
    push_line("Transfer-Encoding: chunked");
    push_crlf();
    push_line("0");
    close_conn();
    // prefixes, extension, unchecked trailer, excess after the end
    push_line("Transfer-Encoding: chunked");
    push_crlf();
    push_line(" 0x3;ext=1");
    push_text("abcXY");
    push_line("+A");
    push_text("0123456789");
    push_crlf();
    push_line("0");
    push_text("zz");
    close_conn();
    // minus in a size line
    push_line("Transfer-Encoding: chunked");
    push_crlf();
    push_line("-5");
    close_conn();
    // saturating chunk size, truncated
    push_line("Transfer-Encoding: chunked");
    push_crlf();
    push_line("FFFFFFFFFFF");
    push_text("data");
    close_conn();
    // truncated header, then a second close
    push_text("GET");
    close_conn();
    close_conn();
  endtask

  // ---------------------------------------------------------------- driver

  // Present the next request at the falling edge once the current one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_reqs.size() == 0 ||
          (pending_reqs[0].drain && expected_frames.size() != 0) ||
          $urandom_range(99) < pending_reqs[0].send_idle) begin
        in_valid <= 1'b0;
      end else begin
        in_flight = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_byte <= in_flight.b;
        in_conn_end <= in_flight.end_conn;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endtask

  frame_t seen_frame;
  frame_t want_frame;
  frame_t new_frame;
  logic   new_valid;

  // Check results, then predict from the request taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen_frame = {out_byte, out_has_byte, out_in_body, out_last, out_complete};
        if (expected_frames.size() == 0) begin
          flag_error($sformatf("unexpected result byte=%h has=%b body=%b last=%b cmpl=%b",
                               out_byte, out_has_byte, out_in_body, out_last,
                               out_complete));
        end else begin
          want_frame = expected_frames.pop_front();
          if (seen_frame.data !== want_frame.data ||
              seen_frame.has_byte !== want_frame.has_byte ||
              seen_frame.in_body !== want_frame.in_body ||
              seen_frame.last !== want_frame.last ||
              seen_frame.complete !== want_frame.complete) begin
            flag_error($sformatf({"result mismatch exp/act: byte %h/%h has %b/%b ",
                                  "body %b/%b last %b/%b cmpl %b/%b"},
                                 want_frame.data, seen_frame.data,
                                 want_frame.has_byte, seen_frame.has_byte,
                                 want_frame.in_body, seen_frame.in_body,
                                 want_frame.last, seen_frame.last,
                                 want_frame.complete, seen_frame.complete));
          end
        end
      end
      in_took = in_valid && in_ready;
      if (in_took) begin
        frame_byte(in_byte, in_conn_end, new_valid, new_frame);
        if (new_valid) expected_frames.push_back(new_frame);
        if (in_flight.hold) hold_asked++;
        recv_idle_pct = in_flight.recv_idle;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int send_pct[4];
    int recv_pct[4];
    int target;
    send_pct = '{0, 60, 0, 25};
    recv_pct = '{0, 0, 60, 25};
    framer_clear();
    in_flight = '{b: 8'h00, end_conn: 1'b0, send_idle: 0, recv_idle: 0,
                  hold: 1'b0, drain: 1'b0};

    add_directed();
    target = pending_reqs.size();
    // random traffic in idle phases; each phase starts from a drained block
    for (int p = 0; p < 4; p++) begin
      gen_send_idle = send_pct[p];
      gen_recv_idle = recv_pct[p];
      drain_next = 1'b1;
      hold_next = (p == 0 || p == 2);
      target += PHASE_REQS;
      while (pending_reqs.size() < target) add_message();
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid || expected_frames.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("** http_request_body_framer: PASSED **");
    end else begin
      $display("** http_request_body_framer: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("** http_request_body_framer: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
rtl/hrbf_pkg.sv
rtl/hrbf_size_parse.sv
rtl/hrbf_hdr_scan.sv
rtl/http_request_body_framer.sv
rtl/hrbf_checker.sv
bench/tb_top.sv
